// ===== sv/rdmp_pkg.sv =====
// Package with the shared constants and types of the row maximum path block.
package rdmp_pkg;

   // Widest row the column counter tracks
   localparam int MAX_COLS = 1024;
   localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   // Field widths
   localparam int VALUE_W = 16;
   localparam int SCORE_W = 32;

   // Last column index the counter may reach
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_COLS - 1);

   // Top-two search state carried from cell to cell
   typedef struct packed {
      logic [SCORE_W-1:0] prev_best;
      logic [COL_W-1:0]   prev_best_col;
      logic [SCORE_W-1:0] prev_second;
      logic [SCORE_W-1:0] cur_best;
      logic [COL_W-1:0]   cur_best_col;
      logic [SCORE_W-1:0] cur_second;
      logic [COL_W-1:0]   col_count;
      logic               first_row;
   } rdmp_state_type;

   // One grid cell
   typedef struct packed {
      logic [VALUE_W-1:0] cell_value;
      logic               last_in_row;
      logic               last_in_grid;
   } rdmp_cell_type;

   localparam rdmp_state_type STATE_RESET = '{
      prev_best:     '0,
      prev_best_col: '0,
      prev_second:   '0,
      cur_best:      '0,
      cur_best_col:  '0,
      cur_second:    '0,
      col_count:     '0,
      first_row:     1'b1
   };

endpackage

// ===== sv/rdmp_update.sv =====
// Score and top-two update for one grid cell.
module rdmp_update (
   input  rdmp_pkg::rdmp_state_type         state,
   input  rdmp_pkg::rdmp_cell_type          cell_in,
   output rdmp_pkg::rdmp_state_type         state_next,
   output logic                             result_valid,
   output logic [rdmp_pkg::SCORE_W-1:0]     result_value
);
   import rdmp_pkg::*;

   logic [SCORE_W-1:0] addend;
   logic [SCORE_W:0]   sum;
   logic [SCORE_W-1:0] score;
   rdmp_state_type     upd;

   // Pick the previous row's best, or its second when the column repeats
   always_comb begin
      if (state.first_row) begin
         addend = '0;
      end else if (state.col_count == state.prev_best_col) begin
         addend = state.prev_second;
      end else begin
         addend = state.prev_best;
      end
      sum   = {1'b0, addend} + {{(SCORE_W + 1 - VALUE_W){1'b0}}, cell_in.cell_value};
      score = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
   end

   // Insert the score into the running top two and advance the column
   always_comb begin
      upd = state;
      if (score > state.cur_best) begin
         upd.cur_second   = state.cur_best;
         upd.cur_best     = score;
         upd.cur_best_col = state.col_count;
      end else if (score > state.cur_second) begin
         upd.cur_second = score;
      end
      if (state.col_count != LAST_COL) begin
         upd.col_count = state.col_count + COL_W'(1);
      end
   end

   // Close the row or the grid
   always_comb begin
      state_next   = upd;
      result_valid = 1'b0;
      result_value = upd.cur_best;
      if (cell_in.last_in_grid) begin
         state_next   = STATE_RESET;
         result_valid = 1'b1;
      end else if (cell_in.last_in_row) begin
         state_next.prev_best     = upd.cur_best;
         state_next.prev_best_col = upd.cur_best_col;
         state_next.prev_second   = upd.cur_second;
         state_next.cur_best      = '0;
         state_next.cur_best_col  = '0;
         state_next.cur_second    = '0;
         state_next.col_count     = '0;
         state_next.first_row     = 1'b0;
      end
   end

endmodule

// ===== sv/row_dp_max_path_no_same_column_unit.sv =====
// Top level of the streaming maximum path sum with no repeated column.
//
// Cells of a grid arrive in row-major order, one per transaction, and the
// block accepts a cell in every cycle: each cell's score (value plus the
// previous row's best or second-best), its saturation and the top-two update
// are done combinationally between the accepted transaction and the state and
// result registers. A cell flagged as last of the grid yields one result
// transaction with the largest final score, saturated at 32 bits, in the next
// cycle; the state then returns to reset for the next grid. Input stalls only
// while a result is held and the result side is not ready. Rows longer than
// MAX_COLS cells keep counting in the last column.
module row_dp_max_path_no_same_column_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] cell_value
   input  logic        req_tlast,   // last_in_row
   input  logic        req_tuser,   // [0] last_in_grid
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] best_total
);
   import rdmp_pkg::*;

   rdmp_state_type     state_ff, state_in;
   rdmp_cell_type      req_cell;
   logic               req_fire;
   logic               res_valid;
   logic [SCORE_W-1:0] res_value;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0] rsp_data_ff, rsp_data_in;

   // Accept a cell whenever the result register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign req_cell.cell_value   = req_tdata[VALUE_W-1:0];
   assign req_cell.last_in_row  = req_tlast;
   assign req_cell.last_in_grid = req_tuser;

   rdmp_update u_update (
      .state        (state_ff),
      .cell_in      (req_cell),
      .state_next   (state_in),
      .result_valid (res_valid),
      .result_value (res_value)
   );

   // Hold or load the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_fire && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A grid end always leaves a result pending in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser) |=> rsp_valid_ff)
      else $error("grid end did not produce a result");

   // A grid end returns the search to the first-row state
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser) |=> (state_ff.first_row && state_ff.col_count == '0))
      else $error("state not cleared after grid end");

   // The running best never falls below the running second
   assert property (@(posedge clock) disable iff (reset)
      state_ff.cur_best >= state_ff.cur_second)
      else $error("top-two order broken");

   // A row end without grid end clears the current search
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast && !req_tuser)
         |=> (!state_ff.first_row && state_ff.cur_best == '0 && state_ff.col_count == '0))
      else $error("row end did not restart the search");

endmodule
